>>> rtl/core/ltwm_pkg.sv
// Shared constants and types for the loop timing window monitor.
package ltwm_pkg;

   localparam int DEPTH_MAX = 16;
   localparam int IDX_W     = $clog2(DEPTH_MAX);
   localparam int CNT_W     = $clog2(DEPTH_MAX + 1);
   localparam int TS_W      = 32;
   localparam int RATE_W    = 26;
   localparam int DIV_W     = 32;
   localparam int STEP_W    = $clog2(DIV_W + 1);
   localparam int CFG_W     = 5;

   localparam logic [CFG_W-1:0] DEPTH_RESET = CFG_W'(DEPTH_MAX);
   // 1000 in 16.16 fixed point: the numerator of the rate division
   localparam logic [DIV_W-1:0] RATE_NUM    = DIV_W'(1000 * 65536);

   typedef logic [TS_W-1:0]  ts_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/core/loop_timing_window_monitor.sv
// Loop timing window monitor: start/end mark windows, mean gap, rate, mean exec time.
//
//  channel | dir | handshake                 | beat contents
//  req_    | in  | req_tvalid / req_tready   | tdata: timestamp_ms; tuser: command
//  rsp_    | out | rsp_tvalid / rsp_tready   | tdata: means and rate; tuser: rate_valid
//  csr_    | in  | csr_wr_en                 | csr_wr_data: window_depth
//
//  One beat at a time: req_tready is high only while the sequencer is idle.
//  A start mark reads the oldest start from the window, then runs two 32-step
//  divisions on the shared divider; the rate division is skipped when the mean
//  comes out zero, and with fewer than two starts held no division runs.
//  An end mark reads one matched pair at a time through the ring read ports,
//  then runs one 32-step division; with no pairs, no division runs.
//  The result waits in an output register; a new beat is taken while it waits,
//  and a finished result holds until the output register is free.
//  Reset is synchronous; the rings need no clearing since counts gate every read.
module loop_timing_window_monitor
   import ltwm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,   // window_depth
   // input marks
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,     // [31:0] timestamp_ms
   input  logic [0:0]       req_tuser,     // [0] command (0 start, 1 end)
   // results
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [95:0]      rsp_tdata,     // [31:0] mean_cycle_time,
                                           // [57:32] cycle_rate,
                                           // [89:58] mean_exec_time, rest zero
   output logic [0:0]       rsp_tuser      // [0] rate_valid
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ST_READ,
      S_ST_DIFF,
      S_DIV_MEAN,
      S_DIV_RATE,
      S_EN_ADDR,
      S_EN_ACC,
      S_EX_DIV,
      S_FINISH
   } state_type;

   state_type        state_ff;
   logic [CFG_W-1:0] depth_ff;
   cnt_type          st_cnt_ff, en_cnt_ff;
   idx_type          st_head_ff, en_head_ff;
   ts_type           ts_ff;
   cnt_type          k_ff;
   cnt_type          pairs_ff;
   ts_type           sum_ff;
   ts_type           cycle_ff, exec_ff;
   logic [RATE_W-1:0] rate_ff;
   logic             rate_ok_ff;
   logic             div_start_ff;
   logic [DIV_W-1:0] div_num_ff, div_den_ff;
   logic             rsp_valid_ff;
   logic [95:0]      rsp_data_ff;
   logic             rsp_user_ff;

   logic             accept;
   logic             cmd;
   cnt_type          eff_depth;
   cnt_type          cnt_sel, cnt_next;
   cnt_type          pairs_next;
   idx_type          rd_idx;
   ts_type           st_rd, en_rd;
   ts_type           sum_next;
   logic [DIV_W-1:0] div_q;
   div_status_type   div_st;

   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tuser[0];
   assign req_tready = (state_ff == S_IDLE);

   // clamp the window depth to [1, DEPTH_MAX]
   always_comb begin
      if (depth_ff == '0) begin
         eff_depth = CNT_W'(1);
      end else if (CNT_W'(depth_ff) > CNT_W'(DEPTH_MAX)) begin
         eff_depth = CNT_W'(DEPTH_MAX);
      end else begin
         eff_depth = CNT_W'(depth_ff);
      end
   end

   // count after a push: grow to full, drop one oldest only when over depth
   always_comb begin
      cnt_sel  = cmd ? en_cnt_ff : st_cnt_ff;
      cnt_next = (cnt_sel < CNT_W'(DEPTH_MAX)) ? cnt_sel + CNT_W'(1) : cnt_sel;
      if (cnt_next > eff_depth && cnt_next > CNT_W'(1)) begin
         cnt_next = cnt_next - CNT_W'(1);
      end
      pairs_next = (cnt_next < st_cnt_ff) ? cnt_next : st_cnt_ff;
   end

   // entry k counted from the newest: head - 1 - k, modulo the ring size
   assign rd_idx   = st_head_ff - IDX_W'(1) - k_ff[IDX_W-1:0];
   assign sum_next = sum_ff + (en_rd - st_rd);

   ltwm_ring u_start_ring (
      .clock   (clock),
      .wr_en   (accept && !cmd),
      .wr_addr (st_head_ff),
      .wr_data (req_tdata),
      .rd_addr (rd_idx),
      .rd_data (st_rd)
   );

   ltwm_ring u_end_ring (
      .clock   (clock),
      .wr_en   (accept && cmd),
      .wr_addr (en_head_ff),
      .wr_data (req_tdata),
      .rd_addr (en_head_ff - IDX_W'(1) - k_ff[IDX_W-1:0]),
      .rd_data (en_rd)
   );

   ltwm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .quotient (div_q),
      .status   (div_st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= DEPTH_RESET;
         st_cnt_ff    <= '0;
         en_cnt_ff    <= '0;
         st_head_ff   <= '0;
         en_head_ff   <= '0;
         cycle_ff     <= '0;
         rate_ff      <= '0;
         rate_ok_ff   <= 1'b0;
         exec_ff      <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         pairs_ff     <= '0;
      end else begin
         div_start_ff <= 1'b0;
         if (csr_wr_en) begin
            depth_ff <= csr_wr_data;
         end
         // drop the held result once taken; the finish step reloads it itself
         if (rsp_tready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ts_ff <= req_tdata;
                  if (!cmd) begin
                     st_head_ff <= st_head_ff + IDX_W'(1);
                     st_cnt_ff  <= cnt_next;
                     k_ff       <= cnt_next - CNT_W'(1);
                     // a single start changes no mean
                     state_ff   <= (cnt_next < CNT_W'(2)) ? S_FINISH : S_ST_READ;
                  end else begin
                     en_head_ff <= en_head_ff + IDX_W'(1);
                     en_cnt_ff  <= cnt_next;
                     pairs_ff   <= pairs_next;
                     k_ff       <= '0;
                     sum_ff     <= '0;
                     state_ff   <= (pairs_next == '0) ? S_FINISH : S_EN_ADDR;
                  end
               end
            end
            S_ST_READ: begin
               // oldest start is being read
               state_ff <= S_ST_DIFF;
            end
            S_ST_DIFF: begin
               // gaps telescope: newest minus oldest over count - 1 gaps
               div_num_ff   <= ts_ff - st_rd;
               div_den_ff   <= DIV_W'(st_cnt_ff - CNT_W'(1));
               div_start_ff <= 1'b1;
               state_ff     <= S_DIV_MEAN;
            end
            S_DIV_MEAN: begin
               if (div_st.done) begin
                  cycle_ff <= div_q;
                  if (div_q != '0) begin
                     div_num_ff   <= RATE_NUM;
                     div_den_ff   <= div_q;
                     div_start_ff <= 1'b1;
                     state_ff     <= S_DIV_RATE;
                  end else begin
                     // zero mean: hold the rate, flag it invalid
                     rate_ok_ff <= 1'b0;
                     state_ff   <= S_FINISH;
                  end
               end
            end
            S_DIV_RATE: begin
               if (div_st.done) begin
                  rate_ff    <= div_q[RATE_W-1:0];
                  rate_ok_ff <= 1'b1;
                  state_ff   <= S_FINISH;
               end
            end
            S_EN_ADDR: begin
               state_ff <= S_EN_ACC;
            end
            S_EN_ACC: begin
               // accumulate one matched pair, then advance
               sum_ff <= sum_next;
               k_ff   <= k_ff + CNT_W'(1);
               if (k_ff + CNT_W'(1) == pairs_ff) begin
                  div_num_ff   <= sum_next;
                  div_den_ff   <= DIV_W'(pairs_ff);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_EX_DIV;
               end else begin
                  state_ff <= S_EN_ADDR;
               end
            end
            S_EX_DIV: begin
               if (div_st.done) begin
                  exec_ff  <= div_q;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'b0, exec_ff, rate_ff, cycle_ff};
                  rsp_user_ff  <= rate_ok_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

>>> rtl/core/ltwm_ring.sv
// Timestamp ring memory: one write port, one registered read port.
module ltwm_ring
   import ltwm_pkg::*;
(
   input  logic    clock,
   input  logic    wr_en,
   input  idx_type wr_addr,
   input  ts_type  wr_data,
   input  idx_type rd_addr,
   output ts_type  rd_data
);

   ts_type mem [DEPTH_MAX];
   ts_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ltwm_divider.sv
// Restoring divider, one quotient bit per cycle.
module ltwm_divider
   import ltwm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output div_status_type   status
);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = STEP_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit; subtract when it fits
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
